[hdl/mswg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mswg_pkg;

	localparam int MAX_SAMPLES_PER_BIT = 64;
	localparam int SINE_TABLE_DEPTH    = 256;
	localparam int SAMPLE_WIDTH        = 16;

	// Field widths fixed by the interface
	localparam int SPB_W   = 7;
	localparam int RAMP_W  = 7;
	localparam int STEP_W  = 17;
	localparam int LEVEL_W = 16;
	localparam int POS_W   = 16;

	// Per-bit sample counter, must hold MAX_SAMPLES_PER_BIT itself
	localparam int CNT_W    = $clog2(MAX_SAMPLES_PER_BIT + 1);
	localparam int WEIGHT_W = 17;
	localparam int ADDR_W   = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int LINE_W   = POS_W + 1;

	localparam logic [WEIGHT_W-1:0] PHASE_ONE  = WEIGHT_W'(65536);
	localparam logic [LINE_W-1:0]   POS_LIMIT  = LINE_W'(65536);
	localparam logic [LEVEL_W-1:0]  SAMPLE_MAX = LEVEL_W'((1 << SAMPLE_WIDTH) - 1);

	localparam int QUEUE_DEPTH = 2;

	localparam longint unsigned ONE_Q30     = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_BIT_SAMPLES = 3'd0,
		REG_RAMP_LEN    = 3'd1,
		REG_PHASE_STEP  = 3'd2,
		REG_LEVEL_LO    = 3'd3,
		REG_LEVEL_HI    = 3'd4,
		REG_LINE_START  = 3'd5,
		REG_LINE_LEN    = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic [SPB_W-1:0]   bit_samples;
		logic [RAMP_W-1:0]  ramp_length;
		logic [STEP_W-1:0]  ramp_phase_step;
		logic [LEVEL_W-1:0] level_lo;
		logic [LEVEL_W-1:0] level_hi;
		logic [POS_W-1:0]   line_start;
		logic [POS_W-1:0]   line_length;
	} cfg_t;

	// One bit's worth of work handed from front to back
	typedef struct packed {
		logic             data_bit;
		logic [POS_W-1:0] pos;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] ramp_first;
		logic [CNT_W-1:0] ramp_len;
	} desc_t;

	typedef logic [WEIGHT_W-1:0] weight_rom_t [0:SINE_TABLE_DEPTH];

	// sin^2 quarter wave in Q16, Horner series in Q30
	function automatic weight_rom_t build_weight_rom();
		weight_rom_t     rom;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned w;
		for (int a = 0; a <= SINE_TABLE_DEPTH; a++) begin
			x  = (HALF_PI_Q30 * longint'(a)) / SINE_TABLE_DEPTH;
			x2 = (x * x) >> 30;
			t  = ONE_Q30 - x2 / 110;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
			t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
			s  = (x * t) >> 30;
			w  = (s * s + (64'd1 << 43)) >> 44;
			if (w > 64'd65536) begin
				w = 64'd65536;
			end
			rom[a] = WEIGHT_W'(w);
		end
		return rom;
	endfunction

	localparam weight_rom_t WEIGHT_ROM = build_weight_rom();

	function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
		return (v > SAMPLE_MAX) ? SAMPLE_MAX : v;
	endfunction

endpackage

`default_nettype wire

[hdl/mswg_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module mswg_fifo import mswg_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t push_desc,
	input  wire logic  pop,
	output logic       full,
	output logic       head_valid,
	output desc_t      head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	desc_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

`default_nettype wire

[hdl/mswg_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module mswg_front import mswg_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire logic  data_bit,
	input  wire logic  new_line,
	input  wire logic  queue_full,
	output logic       push,
	output desc_t      push_desc
);

	logic [LINE_W-1:0]   line_pos_q;
	logic [LINE_W-1:0]   pos;
	logic [CNT_W-1:0]    spb;
	logic [CNT_W-1:0]    ramp;
	logic [LINE_W-1:0]   avail;
	logic [CNT_W-1:0]    count;
	logic [LINE_W:0]     pos_sum;
	logic                accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		pos = new_line ? LINE_W'(cfg.line_start) : line_pos_q;

		if (32'(cfg.bit_samples) > 32'(MAX_SAMPLES_PER_BIT)) begin
			spb = CNT_W'(MAX_SAMPLES_PER_BIT);
		end else begin
			spb = CNT_W'(cfg.bit_samples);
		end

		ramp = (32'(cfg.ramp_length) > 32'(spb)) ? spb : CNT_W'(cfg.ramp_length);

		// samples left before the line end
		if (pos >= LINE_W'(cfg.line_length)) begin
			avail = '0;
		end else begin
			avail = LINE_W'(cfg.line_length) - pos;
		end
		count = (avail < LINE_W'(spb)) ? CNT_W'(avail) : spb;

		pos_sum = (LINE_W + 1)'(pos) + (LINE_W + 1)'(spb);

		push_desc.data_bit   = data_bit;
		push_desc.pos        = pos[POS_W-1:0];
		push_desc.count      = count;
		push_desc.ramp_first = (spb >> 1) - (ramp >> 1);
		push_desc.ramp_len   = ramp;

		push = accept && (count != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pos_q <= '0;
		end else if (accept) begin
			if (spb == '0) begin
				line_pos_q <= pos;
			end else if (pos_sum > (LINE_W + 1)'(POS_LIMIT)) begin
				line_pos_q <= POS_LIMIT;
			end else begin
				line_pos_q <= pos_sum[LINE_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

[hdl/mswg_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module mswg_back import mswg_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cfg_t          cfg,
	input  wire logic          head_valid,
	input  wire desc_t         head,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [LEVEL_W-1:0] sample_level,
	output logic [POS_W-1:0]   sample_index,
	output logic               last,
	output logic [WEIGHT_W-1:0] phase
);

	localparam int PROD_W = WEIGHT_W + LEVEL_W;

	logic [CNT_W-1:0]    j_q;
	logic [WEIGHT_W-1:0] phase_q;

	logic                valid_s1;
	logic [WEIGHT_W-1:0] weight_s1;
	logic [LEVEL_W-1:0]  start_s1;
	logic [LEVEL_W-1:0]  mag_s1;
	logic                neg_s1;
	logic [POS_W-1:0]    index_s1;
	logic                last_s1;

	logic                valid_s2;
	logic [PROD_W-1:0]   prod_s2;
	logic [LEVEL_W-1:0]  start_s2;
	logic                neg_s2;
	logic [POS_W-1:0]    index_s2;
	logic                last_s2;

	logic                out_valid_q;

	logic                advance;
	logic                issue;
	logic                final_j;
	logic                in_before;
	logic                in_ramp;
	logic [CNT_W:0]      ramp_stop;
	logic [31:0]         addr_full;
	logic [ADDR_W-1:0]   addr;
	logic [WEIGHT_W-1:0] weight;
	logic [LEVEL_W-1:0]  lo;
	logic [LEVEL_W-1:0]  hi;
	logic [LEVEL_W-1:0]  lvl_start;
	logic [LEVEL_W-1:0]  lvl_end;
	logic [WEIGHT_W:0]   phase_sum;
	logic [WEIGHT_W-1:0] phase_next;
	logic [PROD_W:0]     prod_up;
	logic [LEVEL_W-1:0]  level;

	assign advance   = !out_valid_q || out_ready;
	assign issue     = advance && head_valid;
	assign final_j   = (j_q == head.count - 1'b1);
	assign pop       = issue && final_j;
	assign out_valid = out_valid_q;
	assign phase     = phase_q;

	always_comb begin
		ramp_stop = (CNT_W + 1)'(head.ramp_first) + (CNT_W + 1)'(head.ramp_len);
		in_before = (j_q < head.ramp_first);
		in_ramp   = !in_before && ((CNT_W + 1)'(j_q) < ramp_stop);

		// Q16 phase to table address, rounded
		addr_full = 32'(phase_q) * 32'(SINE_TABLE_DEPTH) + 32'd32768;
		addr      = ADDR_W'(addr_full >> 16);

		// flat parts reuse the ramp path: zero weight before, full weight after
		if (in_before) begin
			weight = '0;
		end else if (in_ramp) begin
			weight = WEIGHT_ROM[addr];
		end else begin
			weight = PHASE_ONE;
		end

		lo        = clamp_level(cfg.level_lo);
		hi        = clamp_level(cfg.level_hi);
		lvl_start = head.data_bit ? lo : hi;
		lvl_end   = head.data_bit ? hi : lo;

		phase_sum  = (WEIGHT_W + 1)'(phase_q) + (WEIGHT_W + 1)'(cfg.ramp_phase_step);
		phase_next = (phase_sum > (WEIGHT_W + 1)'(PHASE_ONE)) ? PHASE_ONE
			: phase_sum[WEIGHT_W-1:0];

		// negative swing takes the ceiling so the floor of the level is exact
		prod_up = (PROD_W + 1)'(prod_s2) + (PROD_W + 1)'(16'hFFFF);
		if (neg_s2) begin
			level = start_s2 - LEVEL_W'(prod_up >> 16);
		end else begin
			level = start_s2 + LEVEL_W'(prod_s2 >> 16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q         <= '0;
			phase_q     <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= head_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
			if (head_valid) begin
				if (final_j) begin
					j_q     <= '0;
					phase_q <= '0;
				end else begin
					j_q <= j_q + 1'b1;
					if (in_ramp) begin
						phase_q <= phase_next;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			weight_s1 <= weight;
			start_s1  <= lvl_start;
			neg_s1    <= (lvl_start > lvl_end);
			mag_s1    <= (lvl_start > lvl_end) ? lvl_start - lvl_end : lvl_end - lvl_start;
			index_s1  <= head.pos + POS_W'(j_q);
			last_s1   <= final_j;

			prod_s2  <= PROD_W'(weight_s1) * PROD_W'(mag_s1);
			start_s2 <= start_s1;
			neg_s2   <= neg_s1;
			index_s2 <= index_s1;
			last_s2  <= last_s1;

			sample_level <= level;
			sample_index <= index_s2;
			last         <= last_s2;
		end
	end

endmodule

`default_nettype wire

[hdl/manchester_shaped_waveform_gen.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// -------   ---------------------  ----------------------------------------
// in        in_valid / in_ready    data_bit, new_line (one data bit)
// out       out_valid / out_ready  sample_level, sample_index, last
// cfg       cfg_write              cfg_index, cfg_data (write only)
//
// One sample per cycle unless the output stalls; the back sequencer sets
// the rate. A bit gives min(bit_samples, 64) samples, fewer at the line end.
// A bit's first sample passes the s1, s2 and output registers.
// Reset clears position, pointers and valids; no clearing pass is needed.
// Output stalls freeze the whole back pipe; the two-entry queue keeps
// requests flowing in until it fills, then in_ready drops.

module manchester_shaped_waveform_gen import mswg_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [STEP_W-1:0]  cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               data_bit,
	input  wire logic               new_line,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [LEVEL_W-1:0]      sample_level,
	output logic [POS_W-1:0]        sample_index,
	output logic                    last
);

	cfg_t                cfg_q;
	logic                queue_full;
	logic                push;
	desc_t               push_desc;
	logic                pop;
	logic                head_valid;
	desc_t               head;
	logic [WEIGHT_W-1:0] phase;

	// Register file; index 7 is unused and ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_samples     <= SPB_W'(16);
			cfg_q.ramp_length     <= '0;
			cfg_q.ramp_phase_step <= '0;
			cfg_q.level_lo        <= '0;
			cfg_q.level_hi        <= LEVEL_W'(65535);
			cfg_q.line_start      <= '0;
			cfg_q.line_length     <= POS_W'(4096);
		end else if (cfg_write) begin
			unique case (reg_index_t'(cfg_index))
				REG_BIT_SAMPLES: cfg_q.bit_samples     <= cfg_data[SPB_W-1:0];
				REG_RAMP_LEN:    cfg_q.ramp_length     <= cfg_data[RAMP_W-1:0];
				REG_PHASE_STEP:  cfg_q.ramp_phase_step <= cfg_data;
				REG_LEVEL_LO:    cfg_q.level_lo        <= cfg_data[LEVEL_W-1:0];
				REG_LEVEL_HI:    cfg_q.level_hi        <= cfg_data[LEVEL_W-1:0];
				REG_LINE_START:  cfg_q.line_start      <= cfg_data[POS_W-1:0];
				REG_LINE_LEN:    cfg_q.line_length     <= cfg_data[POS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front: takes bits, tracks line position, queues sample runs
	mswg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_bit   (data_bit),
		.new_line   (new_line),
		.queue_full (queue_full),
		.push       (push),
		.push_desc  (push_desc)
	);

	mswg_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head)
	);

	// Back: one sample a cycle unless stalled, ROM weight, multiply, level, output register
	mswg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_level (sample_level),
		.sample_index (sample_index),
		.last         (last),
		.phase        (phase)
	);

	// Queue never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !queue_full)
		else $error("push into full queue");

	// Emitted positions always lie inside the line
	a_index_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sample_index < cfg_q.line_length))
		else $error("sample index beyond line length");

	// Ramp phase saturates at one
	a_phase_sat: assert property (@(posedge clk) disable iff (!arst_n)
		phase <= PHASE_ONE)
		else $error("ramp phase above one");

	// A stalled output request holds still until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(sample_level)
			&& $stable(sample_index) && $stable(last)))
		else $error("output request changed while stalled");

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top import mswg_pkg::*;;

	localparam int          MAX_REPORTS    = 10;
	localparam int          DRAIN_PAD      = 200;   // bits with no samples still cost cycles
	localparam int          WATCHDOG_LIMIT = 2000;  // cycles with no accepted request
	localparam int          RX_HOLD        = 400;   // long output stall, fills the input queue
	localparam int          RAND_PHASES    = 12;
	localparam int unsigned POS_CAP        = 65536;
	localparam int unsigned LEVEL_CAP      = (1 << SAMPLE_WIDTH) - 1;
	localparam longint unsigned Q30_ONE     = 64'd1073741824;
	localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [POS_W-1:0]   index;
		logic               last;
	} sample_t;

	// Directed stimulus rows: a register write, a bit checked by the shadow model,
	// or a bit whose hard-step samples are typed in directly.
	typedef enum logic [1:0] {ROW_CFG, ROW_BIT, ROW_KNOWN} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		reg_index_t         reg_sel;
		logic [STEP_W-1:0]  data;
		logic               b;
		logic               nl;
		int                 n;       // samples expected
		int                 half;    // first offset at the second level
		logic [LEVEL_W-1:0] lvl_a;
		logic [LEVEL_W-1:0] lvl_b;
		logic [POS_W-1:0]   idx0;
	} stim_row_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               cfg_write    = 1'b0;
	logic [2:0]         cfg_index    = REG_BIT_SAMPLES;
	logic [STEP_W-1:0]  cfg_data     = '0;
	logic               in_valid     = 1'b0;
	logic               in_ready;
	logic               data_bit     = 1'b0;
	logic               new_line     = 1'b0;
	logic               out_valid;
	logic               out_ready    = 1'b0;
	logic [LEVEL_W-1:0] sample_level;
	logic [POS_W-1:0]   sample_index;
	logic               last;

	// Shadow registers and line position
	logic [SPB_W-1:0]   sh_spb;
	logic [RAMP_W-1:0]  sh_ramp;
	logic [STEP_W-1:0]  sh_step;
	logic [LEVEL_W-1:0] sh_low;
	logic [LEVEL_W-1:0] sh_high;
	logic [POS_W-1:0]   sh_lstart;
	logic [POS_W-1:0]   sh_llen;
	logic [LINE_W-1:0]  sh_pos;

	int unsigned weight_tab [0:SINE_TABLE_DEPTH];

	sample_t   sample_fifo[$];
	stim_row_t stim_rows[$];
	int        mismatches  = 0;
	int        tx_idle_pct = 30;
	int        rx_idle_pct = 30;
	bit        hold_start  = 1'b0;

	manchester_shaped_waveform_gen DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_bit     (data_bit),
		.new_line     (new_line),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_level (sample_level),
		.sample_index (sample_index),
		.last         (last)
	);

	always #6 clk = ~clk;

	// sin^2(pi/2 * a / DEPTH) in Q16. Sine by a nested Taylor series in Q30,
	// innermost term first; every product truncated, every division floored.
	function automatic int unsigned sin_sq_weight(input int unsigned addr);
		longint unsigned ang;
		longint unsigned ang2;
		longint unsigned acc;
		longint unsigned sn;
		longint unsigned wq;
		int unsigned     divs [5];
		divs = '{110, 72, 42, 20, 6};
		ang  = (Q30_HALF_PI * 64'(addr)) / 64'(SINE_TABLE_DEPTH);
		ang2 = (ang * ang) >> 30;
		acc  = Q30_ONE;
		foreach (divs[k]) begin
			acc = Q30_ONE - ((ang2 * acc) >> 30) / 64'(divs[k]);
		end
		sn = (ang * acc) >> 30;
		wq = (sn * sn + (64'd1 << 43)) >> 44;
		return (wq > 64'd65536) ? 32'd65536 : 32'(wq);
	endfunction

	// Level of ramp sample i between st and en, floored toward minus infinity
	function automatic int unsigned ramp_sample(input int unsigned i, input int unsigned st,
		input int unsigned en);
		longint unsigned ph;
		longint unsigned a;
		longint unsigned w;
		ph = 64'(i) * 64'(sh_step);
		if (ph > 64'd65536) begin
			ph = 64'd65536;
		end
		a = (ph * 64'(SINE_TABLE_DEPTH) + 64'd32768) >> 16;
		if (a > 64'(SINE_TABLE_DEPTH)) begin
			a = 64'(SINE_TABLE_DEPTH);
		end
		w = 64'(weight_tab[a]);
		if (en >= st) begin
			return st + 32'((w * 64'(en - st)) >> 16);
		end
		return st - 32'((w * 64'(st - en) + 64'd65535) >> 16);
	endfunction

	// Expands one accepted bit into its samples and moves the line position.
	// With emit low only the position is moved (samples typed in elsewhere).
	function automatic void predict_bit(input logic b, input logic nl, input bit emit);
		int unsigned spb;
		int unsigned r;
		int unsigned rstart;
		int unsigned lo;
		int unsigned hi;
		int unsigned st;
		int unsigned en;
		int unsigned lvl;
		int unsigned p;
		int unsigned nxt;
		sample_t     s;
		if (nl) begin
			sh_pos = {1'b0, sh_lstart};
		end
		if (sh_spb == 0) begin
			return;
		end
		spb    = (sh_spb > MAX_SAMPLES_PER_BIT) ? MAX_SAMPLES_PER_BIT : sh_spb;
		r      = (sh_ramp > spb) ? spb : sh_ramp;
		rstart = spb / 2 - r / 2;
		lo     = (sh_low > LEVEL_CAP) ? LEVEL_CAP : sh_low;
		hi     = (sh_high > LEVEL_CAP) ? LEVEL_CAP : sh_high;
		st     = b ? lo : hi;
		en     = b ? hi : lo;
		for (int unsigned j = 0; j < spb; j++) begin
			p = sh_pos + j;
			if (p >= sh_llen) begin
				break;
			end
			if (r == 0) begin
				lvl = (j < spb / 2) ? st : en;
			end else if (j < rstart) begin
				lvl = st;
			end else if (j - rstart < r) begin
				lvl = ramp_sample(j - rstart, st, en);
			end else begin
				lvl = en;
			end
			s.level = lvl[LEVEL_W-1:0];
			s.index = p[POS_W-1:0];
			s.last  = (j == spb - 1) || (p + 1 >= sh_llen);
			if (emit) begin
				sample_fifo.push_back(s);
			end
		end
		nxt    = sh_pos + spb;
		sh_pos = (nxt > POS_CAP) ? POS_CAP[LINE_W-1:0] : nxt[LINE_W-1:0];
	endfunction

	function automatic void add_cfg(input reg_index_t r, input int unsigned v);
		stim_row_t t;
		t.kind    = ROW_CFG;
		t.reg_sel = r;
		t.data    = v[STEP_W-1:0];
		stim_rows.push_back(t);
	endfunction

	function automatic void add_bit(input logic b, input logic nl);
		stim_row_t t;
		t.kind = ROW_BIT;
		t.b    = b;
		t.nl   = nl;
		stim_rows.push_back(t);
	endfunction

	function automatic void add_known(input logic b, input logic nl, input int n, input int half,
		input int unsigned lvl_a, input int unsigned lvl_b, input int unsigned idx0);
		stim_row_t t;
		t.kind  = ROW_KNOWN;
		t.b     = b;
		t.nl    = nl;
		t.n     = n;
		t.half  = half;
		t.lvl_a = lvl_a[LEVEL_W-1:0];
		t.lvl_b = lvl_b[LEVEL_W-1:0];
		t.idx0  = idx0[POS_W-1:0];
		stim_rows.push_back(t);
	endfunction

	// One register write: strobe for a cycle, then drop it. The shadow copy
	// takes the value at once; writes only happen with the block idle.
	task automatic write_reg(input reg_index_t r, input int unsigned v);
		cfg_write <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v[STEP_W-1:0];
		unique case (r)
			REG_BIT_SAMPLES: sh_spb    = v[SPB_W-1:0];
			REG_RAMP_LEN:    sh_ramp   = v[RAMP_W-1:0];
			REG_PHASE_STEP:  sh_step   = v[STEP_W-1:0];
			REG_LEVEL_LO:    sh_low    = v[LEVEL_W-1:0];
			REG_LEVEL_HI:    sh_high   = v[LEVEL_W-1:0];
			REG_LINE_START:  sh_lstart = v[POS_W-1:0];
			REG_LINE_LEN:    sh_llen   = v[POS_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one bit request, with random idle cycles ahead of it. Returns at
	// the edge that accepted it; valid stays high so the next request can follow
	// back to back.
	task automatic send_bit(input logic b, input logic nl);
		logic rdy;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_bit <= b;
		new_line <= nl;
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	// Stop offering, wait for every expected sample, then give bits that make
	// no samples time to leave the block.
	task automatic drain();
		in_valid <= 1'b0;
		while (sample_fifo.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	// Output side: random back-pressure, one long hold on request, and the check
	// of every accepted sample against the oldest expected one. Handshakes are
	// sampled on the falling edge: DUT inputs change only right after the rising
	// edge, so that value is the one the DUT acts on at the next rising edge.
	initial begin : sample_sink
		logic    fire;
		sample_t got;
		sample_t want;
		int      hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			fire      = out_valid && out_ready;
			got.level = sample_level;
			got.index = sample_index;
			got.last  = last;
			@(posedge clk);
			if (fire) begin
				if (sample_fifo.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("unexpected sample: level=%0d index=%0d last=%0b",
							got.level, got.index, got.last);
					end
				end else begin
					want = sample_fifo.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display({"sample mismatch: expected level=%0d index=%0d ",
								"last=%0b, got level=%0d index=%0d last=%0b"},
								want.level, want.index, want.last,
								got.level, got.index, got.last);
						end
					end
				end
			end
			if (hold_start) begin
				hold_start = 1'b0;
				hold_left  = RX_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Ends a hung run: too many cycles in a row with no request accepted
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(negedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin : stimulus
		stim_row_t   row;
		sample_t     s;
		bit          prev_bit;
		int          nbits;
		int          pick;
		int unsigned spb_v;
		int unsigned eff;
		int unsigned ramp_v;
		int unsigned step_v;
		int unsigned lo_v;
		int unsigned hi_v;
		int unsigned ls_v;
		int unsigned ll_v;
		logic        b;
		logic        nl;

		for (int a = 0; a <= SINE_TABLE_DEPTH; a++) begin
			weight_tab[a] = sin_sq_weight(a);
		end

		// Reset values of the registers and the line position
		sh_spb    = 7'd16;
		sh_ramp   = '0;
		sh_step   = '0;
		sh_low    = '0;
		sh_high   = 16'hFFFF;
		sh_lstart = '0;
		sh_llen   = 16'd4096;
		sh_pos    = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset: 16 samples per bit, hard step at mid-bit, full swing
		add_known(1'b1, 1'b1, 16, 8, 0, 65535, 0);
		add_known(1'b0, 1'b0, 16, 8, 65535, 0, 16);
		add_known(1'b0, 1'b1, 16, 8, 65535, 0, 0);
		// Widest bit, ramp over the whole bit
		add_cfg(REG_BIT_SAMPLES, 64);
		add_cfg(REG_RAMP_LEN, 64);
		add_cfg(REG_PHASE_STEP, 1040);
		add_cfg(REG_LEVEL_LO, 0);
		add_cfg(REG_LEVEL_HI, 65535);
		add_cfg(REG_LINE_START, 0);
		add_cfg(REG_LINE_LEN, 65535);
		add_bit(1'b1, 1'b1);
		add_bit(1'b0, 1'b0);
		add_bit(1'b1, 1'b0);
		// Oversized bit and ramp, phase past one, inverted levels, line end cut,
		// position saturating past the line
		add_cfg(REG_BIT_SAMPLES, 127);
		add_cfg(REG_RAMP_LEN, 127);
		add_cfg(REG_PHASE_STEP, 131071);
		add_cfg(REG_LEVEL_LO, 65535);
		add_cfg(REG_LEVEL_HI, 0);
		add_cfg(REG_LINE_START, 65500);
		add_bit(1'b1, 1'b1);
		add_bit(1'b0, 1'b0);
		add_bit(1'b1, 1'b0);
		add_bit(1'b0, 1'b1);
		// Hard step cut short by the line end, then a bit wholly past it
		add_cfg(REG_BIT_SAMPLES, 16);
		add_cfg(REG_RAMP_LEN, 0);
		add_cfg(REG_LEVEL_LO, 0);
		add_cfg(REG_LEVEL_HI, 65535);
		add_cfg(REG_LINE_START, 65530);
		add_known(1'b1, 1'b1, 5, 8, 0, 65535, 65530);
		add_bit(1'b1, 1'b0);
		// Zero samples per bit: nothing out, position held
		add_cfg(REG_BIT_SAMPLES, 0);
		add_cfg(REG_LINE_START, 65535);
		add_bit(1'b1, 1'b1);
		add_bit(1'b0, 1'b0);
		// One sample per bit: only the second level shows
		add_cfg(REG_BIT_SAMPLES, 1);
		add_cfg(REG_LEVEL_LO, 100);
		add_cfg(REG_LEVEL_HI, 200);
		add_cfg(REG_LINE_START, 0);
		add_cfg(REG_LINE_LEN, 4096);
		add_known(1'b1, 1'b1, 1, 0, 100, 200, 0);
		add_known(1'b0, 1'b0, 1, 0, 200, 100, 1);
		// One-sample ramp with zero phase step
		add_cfg(REG_BIT_SAMPLES, 2);
		add_cfg(REG_RAMP_LEN, 1);
		add_cfg(REG_PHASE_STEP, 0);
		add_cfg(REG_LEVEL_LO, 0);
		add_cfg(REG_LEVEL_HI, 65535);
		add_bit(1'b1, 1'b1);
		add_bit(1'b0, 1'b0);
		// Odd bit length with an odd ramp
		add_cfg(REG_BIT_SAMPLES, 7);
		add_cfg(REG_RAMP_LEN, 5);
		add_cfg(REG_PHASE_STEP, 16384);
		add_cfg(REG_LEVEL_LO, 1000);
		add_cfg(REG_LEVEL_HI, 60000);
		add_bit(1'b1, 1'b1);
		add_bit(1'b0, 1'b0);
		add_bit(1'b1, 1'b1);
		// Phase step of exactly one, equal levels
		add_cfg(REG_BIT_SAMPLES, 64);
		add_cfg(REG_RAMP_LEN, 64);
		add_cfg(REG_PHASE_STEP, 65536);
		add_cfg(REG_LEVEL_LO, 12345);
		add_cfg(REG_LEVEL_HI, 12345);
		add_bit(1'b0, 1'b1);
		add_bit(1'b1, 1'b0);
		// Empty line
		add_cfg(REG_BIT_SAMPLES, 16);
		add_cfg(REG_LINE_LEN, 0);
		add_bit(1'b1, 1'b1);

		prev_bit = 1'b0;
		foreach (stim_rows[k]) begin
			row = stim_rows[k];
			if (row.kind == ROW_CFG) begin
				if (prev_bit) begin
					drain();
				end
				write_reg(row.reg_sel, row.data);
				prev_bit = 1'b0;
			end else begin
				send_bit(row.b, row.nl);
				predict_bit(row.b, row.nl, row.kind == ROW_BIT);
				if (row.kind == ROW_KNOWN) begin
					for (int j = 0; j < row.n; j++) begin
						s.level = (j < row.half) ? row.lvl_a : row.lvl_b;
						s.index = row.idx0 + POS_W'(j);
						s.last  = (j == row.n - 1);
						sample_fifo.push_back(s);
					end
				end
				prev_bit = 1'b1;
			end
		end

		// Random phases: new settings each time, then a run of bits.
		// Phase 1 runs with no idling at all; phase 3 carries the long output hold
		// and starts a fresh line at zero so every bit makes samples.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			pick = $urandom_range(99);
			if (ph == 3)        spb_v = 16;
			else if (pick < 4)  spb_v = 0;
			else if (pick < 10) spb_v = $urandom_range(65, 127);
			else if (pick < 18) spb_v = 64;
			else if (pick < 30) spb_v = $urandom_range(1, 3);
			else                spb_v = $urandom_range(4, 24);
			eff  = (spb_v > MAX_SAMPLES_PER_BIT) ? MAX_SAMPLES_PER_BIT : spb_v;
			pick = $urandom_range(99);
			if (pick < 25 || eff == 0) ramp_v = 0;
			else if (pick < 40)        ramp_v = $urandom_range(0, 127);
			else                       ramp_v = $urandom_range(1, eff);
			if ($urandom_range(99) < 60) begin
				step_v = (ramp_v > 1) ? 65536 / (ramp_v - 1) : 65536;
			end else begin
				step_v = $urandom_range(0, 131071);
			end
			lo_v = $urandom_range(0, 65535);
			hi_v = $urandom_range(0, 65535);
			pick = $urandom_range(9);
			if (pick == 0) hi_v = lo_v;
			else if (pick == 1) begin
				lo_v = 65535;
				hi_v = 0;
			end
			pick = $urandom_range(99);
			if (ph == 3 || pick < 70) ls_v = 0;
			else if (pick < 90)       ls_v = $urandom_range(0, 4095);
			else                      ls_v = $urandom_range(65400, 65535);
			pick = $urandom_range(99);
			if (ph == 3 || pick < 40) ll_v = 65535;
			else if (pick < 70)       ll_v = $urandom_range(0, 600);
			else                      ll_v = $urandom_range(0, 65535);
			write_reg(REG_BIT_SAMPLES, spb_v);
			write_reg(REG_RAMP_LEN, ramp_v);
			write_reg(REG_PHASE_STEP, step_v);
			write_reg(REG_LEVEL_LO, lo_v);
			write_reg(REG_LEVEL_HI, hi_v);
			write_reg(REG_LINE_START, ls_v);
			write_reg(REG_LINE_LEN, ll_v);

			tx_idle_pct = (ph == 1) ? 0 : 30;
			rx_idle_pct = (ph == 1) ? 0 : 30;
			if (ph == 3) begin
				hold_start = 1'b1;
			end
			nbits = (ph == 1) ? 30 : $urandom_range(12, 20);
			for (int k = 0; k < nbits; k++) begin
				b = 1'($urandom_range(1));
				if (k == 0) begin
					nl = (ph == 3) ? 1'b1 : 1'($urandom_range(1));
				end else begin
					nl = ($urandom_range(9) == 0);
				end
				send_bit(b, nl);
				predict_bit(b, nl, 1'b1);
			end
		end

		drain();
		if (mismatches == 0 && sample_fifo.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
